// ===== rtl/erbp_pkg.sv =====
package erbp_pkg;

   // Ring geometry.
   localparam int SLOTS = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = SLOT_W + 1;

   // Running byte offset during a find: wide enough for all stored lengths
   // and for the 20-bit position.
   localparam int SUM_W = (16 + SLOT_W > 20) ? 16 + SLOT_W : 20;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0] count_type;

   // Operation codes.
   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_FIND    = 2'd2,
      KIND_CONSUME = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] handle;
      logic [15:0] length;
      logic [15:0] start_consumed;
      logic [19:0] position;
      logic [15:0] consume_count;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [31:0] handle_out;
      logic [3:0]  entry_index;
      logic [15:0] byte_within;
      logic [15:0] remaining;
      logic [15:0] length_out;
      logic [15:0] consumed_out;
      logic [15:0] head_available;
   } rsp_type;

   // One stored write record.
   typedef struct packed {
      logic [31:0] handle;
      logic [15:0] length;
      logic [15:0] consumed;
   } record_type;

   // Record store port control.
   typedef struct packed {
      logic     wr_en;
      slot_type wr_addr;
      slot_type rd_addr;
   } mem_ctrl_type;

   // Walk unit control and status.
   typedef struct packed {
      logic clear;
      logic step;
   } walk_ctrl_type;

   typedef struct packed {
      logic        found;
      logic [15:0] offset;
      logic [15:0] remaining;
   } walk_res_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP_RD,
      ST_OP_USE,
      ST_FIND,
      ST_HEAD_RD,
      ST_HEAD_USE,
      ST_DONE
   } state_type;

   // Advance a ring slot with wraparound.
   function automatic slot_type next_slot(input slot_type s);
      slot_type r;
      if (s == slot_type'(SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + slot_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/erbp_store.sv =====
module erbp_store (
   input  logic                 clock,
   input  erbp_pkg::mem_ctrl_type ctrl,
   input  erbp_pkg::record_type wr_data,
   output erbp_pkg::record_type rd_data
);
   import erbp_pkg::*;

   record_type mem [SLOTS];
   record_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctrl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/erbp_walk.sv =====
module erbp_walk (
   input  logic                   clock,
   input  erbp_pkg::walk_ctrl_type ctrl,
   input  logic [15:0]            length,
   input  logic [19:0]            position,
   output erbp_pkg::walk_res_type res
);
   import erbp_pkg::*;

   logic [SUM_W-1:0] start_ff;
   logic [SUM_W-1:0] start_in;
   logic [SUM_W-1:0] end_sum;
   logic [SUM_W-1:0] pos_ext;
   logic [SUM_W-1:0] within_full;

   // Shared adder and comparator: end of the current record and hit test.
   always_comb begin
      pos_ext = SUM_W'(position);
      end_sum = start_ff + SUM_W'(length);
      within_full = pos_ext - start_ff;
      res.found = pos_ext < end_sum;
      res.offset = within_full[15:0];
      res.remaining = length - within_full[15:0];
   end

   // Running start offset of the record under inspection.
   always_comb begin
      start_in = start_ff;
      if (ctrl.clear) begin
         start_in = '0;
      end else if (ctrl.step) begin
         start_in = end_sum;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule

// ===== rtl/entry_ring_with_byte_position_lookup.sv =====
// Ring of write records with byte-position lookup.
//
// Channels: req_* carries one operation (add, remove oldest, find byte
// position, consume from oldest) as a valid/ready transfer; rsp_* returns
// exactly one result per operation, also valid/ready.
// Each operation is worked by a small sequencer over one record store with
// a registered read port. Add, remove and consume step through OP_RD,
// OP_USE, HEAD_RD, HEAD_USE and DONE before the result is registered. A find
// walks one stored record per cycle through the shared adder and comparator
// in state FIND, visiting at most SLOTS records. The next request can be
// taken in the same cycle in which the result turns valid.
// The block accepts a new request only while the sequencer is idle; a
// finished result sits in an output register, so the next request can be
// taken while the receiver stalls. A further result then waits in the
// sequencer until the output register is freed.
// Reset empties the ring (both slot pointers zero, full flag clear) and
// drops any pending result; the record store itself is not cleared.
module entry_ring_with_byte_position_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  erbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output erbp_pkg::rsp_type rsp_data
);
   import erbp_pkg::*;

   state_type state_ff, state_in;
   slot_type  write_slot_ff, write_slot_in;
   slot_type  read_slot_ff, read_slot_in;
   logic      full_ff, full_in;
   slot_type  slot_ff, slot_in;
   count_type cnt_ff, cnt_in;
   req_type   item_ff, item_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      rsp_valid_ff, rsp_valid_in;

   mem_ctrl_type  mem_ctrl;
   record_type    wr_data;
   record_type    rd_data;
   walk_ctrl_type walk_ctrl;
   walk_res_type  walk_res;

   logic      empty;
   count_type stored_n;
   count_type cnt_next;
   logic      find_last;
   logic      out_free;
   slot_type  write_next;
   logic [16:0] consume_sum;

   erbp_store u_store (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   erbp_walk u_walk (
      .clock    (clock),
      .ctrl     (walk_ctrl),
      .length   (rd_data.length),
      .position (item_ff.position),
      .res      (walk_res)
   );

   // Occupancy of the ring.
   always_comb begin
      empty = (write_slot_ff == read_slot_ff) && !full_ff;
      if (full_ff) begin
         stored_n = count_type'(SLOTS);
      end else if (write_slot_ff >= read_slot_ff) begin
         stored_n = count_type'(write_slot_ff) - count_type'(read_slot_ff);
      end else begin
         stored_n = count_type'(write_slot_ff) + count_type'(SLOTS)
                    - count_type'(read_slot_ff);
      end
      cnt_next = cnt_ff + count_type'(1);
      find_last = (cnt_next == stored_n);
      out_free = !rsp_valid_ff || rsp_ready;
      write_next = next_slot(write_slot_ff);
      consume_sum = {1'b0, rd_data.consumed} + {1'b0, item_ff.consume_count};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_OP_RD;
            end
         end
         ST_OP_RD: begin
            if (item_ff.kind == KIND_FIND) begin
               state_in = empty ? ST_HEAD_RD : ST_FIND;
            end else begin
               state_in = ST_OP_USE;
            end
         end
         ST_OP_USE: state_in = ST_HEAD_RD;
         ST_FIND: begin
            if (walk_res.found || find_last) begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD_USE;
         ST_HEAD_USE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: store port, walk unit and request handshake.
   always_comb begin
      req_ready = 1'b0;
      mem_ctrl = '0;
      wr_data = '0;
      walk_ctrl = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_OP_RD: begin
            mem_ctrl.rd_addr = (item_ff.kind == KIND_ADD) ? write_slot_ff : read_slot_ff;
            walk_ctrl.clear = 1'b1;
         end
         ST_OP_USE: begin
            mem_ctrl.rd_addr = read_slot_ff;
            if (item_ff.kind == KIND_ADD) begin
               mem_ctrl.wr_en = 1'b1;
               mem_ctrl.wr_addr = write_slot_ff;
               wr_data.handle = item_ff.handle;
               wr_data.length = item_ff.length;
               wr_data.consumed = item_ff.start_consumed;
            end else if (item_ff.kind == KIND_CONSUME && !empty) begin
               mem_ctrl.wr_en = 1'b1;
               mem_ctrl.wr_addr = read_slot_ff;
               wr_data = rd_data;
               wr_data.consumed = consume_sum[16] ? 16'hFFFF : consume_sum[15:0];
            end
         end
         ST_FIND: begin
            mem_ctrl.rd_addr = next_slot(slot_ff);
            walk_ctrl.step = !walk_res.found;
         end
         ST_HEAD_RD: mem_ctrl.rd_addr = read_slot_ff;
         default: mem_ctrl.rd_addr = read_slot_ff;
      endcase
   end

   // Pointer, walk and result datapath.
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in = read_slot_ff;
      full_in = full_ff;
      slot_in = slot_ff;
      cnt_in = cnt_ff;
      item_in = item_ff;
      res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in = '0;
            end
         end
         ST_OP_RD: begin
            slot_in = read_slot_ff;
            cnt_in = '0;
         end
         ST_OP_USE: begin
            case (item_ff.kind)
               KIND_ADD: begin
                  if (full_ff) begin
                     res_in.evicted = 1'b1;
                     res_in.handle_out = rd_data.handle;
                     read_slot_in = write_next;
                  end else begin
                     full_in = (write_next == read_slot_ff);
                  end
                  write_slot_in = write_next;
               end
               KIND_REMOVE: begin
                  if (!empty) begin
                     res_in.hit = 1'b1;
                     res_in.handle_out = rd_data.handle;
                     res_in.length_out = rd_data.length;
                     res_in.consumed_out = rd_data.consumed;
                     read_slot_in = next_slot(read_slot_ff);
                     full_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_FIND: begin
            if (walk_res.found) begin
               res_in.hit = 1'b1;
               res_in.handle_out = rd_data.handle;
               res_in.entry_index = 4'(slot_ff);
               res_in.byte_within = walk_res.offset;
               res_in.remaining = walk_res.remaining;
            end else begin
               slot_in = next_slot(slot_ff);
               cnt_in = cnt_next;
            end
         end
         ST_HEAD_USE: begin
            if (empty || rd_data.consumed >= rd_data.length) begin
               res_in.head_available = '0;
            end else begin
               res_in.head_available = rd_data.length - rd_data.consumed;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff <= '0;
         full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff <= read_slot_in;
         full_ff <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      cnt_ff <= cnt_in;
      item_ff <= item_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // A full ring always has its two pointers together.
   assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (write_slot_ff == read_slot_ff))
      else $error("full ring with pointers apart");

   // The walk never runs past the stored records.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (cnt_ff < stored_n))
      else $error("find walked past stored records");

   // A new result only appears out of the final sequencer state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside of done state");

   // An eviction result never also claims a hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.evicted))
      else $error("result both hit and evicted");

endmodule
